[rtl/adp_pkg.sv]
`default_nettype none

package adp_pkg;

   localparam int BYTE_W          = 8;
   localparam int VALUE_W         = 64;
   localparam int COUNT_W         = 7;
   localparam int MAX_FIELD_BYTES = 64;
   // room for value*10 + 9 on a full-width accumulator
   localparam int PROD_W          = VALUE_W + 4;

   typedef logic [2:0]         kind_type;
   typedef logic [BYTE_W-1:0]  byte_type;
   typedef logic [VALUE_W-1:0] value_type;
   typedef logic [COUNT_W-1:0] count_type;

   localparam kind_type KIND_INT8   = 3'd0;
   localparam kind_type KIND_INT16  = 3'd1;
   localparam kind_type KIND_INT32  = 3'd2;
   localparam kind_type KIND_INT64  = 3'd3;
   localparam kind_type KIND_UINT8  = 3'd4;
   localparam kind_type KIND_UINT16 = 3'd5;
   localparam kind_type KIND_UINT32 = 3'd6;
   localparam kind_type KIND_UINT64 = 3'd7;

   localparam byte_type CHAR_NUL   = 8'h00;
   localparam byte_type CHAR_MINUS = 8'h2D;
   localparam byte_type CHAR_ZERO  = 8'h30;
   localparam byte_type CHAR_NINE  = 8'h39;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_NULL  = 2'd1,
      STATUS_ERROR = 2'd2
   } status_type;

   typedef struct packed {
      value_type acc;
      logic      minus_seen;
      count_type byte_count;
      logic      overflowed;
      logic      field_open;
   } field_state_type;

   typedef struct packed {
      value_type  parsed_value;
      count_type  consumed_count;
      status_type parse_status;
   } result_type;

   function automatic logic kind_is_signed(kind_type kind);
      return kind < KIND_UINT8;
   endfunction

   // largest positive magnitude the kind can hold
   function automatic value_type kind_pos_max(kind_type kind);
      value_type max_val;
      case (kind)
         KIND_INT8:   max_val = 64'h0000_0000_0000_007F;
         KIND_INT16:  max_val = 64'h0000_0000_0000_7FFF;
         KIND_INT32:  max_val = 64'h0000_0000_7FFF_FFFF;
         KIND_INT64:  max_val = 64'h7FFF_FFFF_FFFF_FFFF;
         KIND_UINT8:  max_val = 64'h0000_0000_0000_00FF;
         KIND_UINT16: max_val = 64'h0000_0000_0000_FFFF;
         KIND_UINT32: max_val = 64'h0000_0000_FFFF_FFFF;
         KIND_UINT64: max_val = 64'hFFFF_FFFF_FFFF_FFFF;
         default:     max_val = '0;
      endcase
      return max_val;
   endfunction

endpackage

`default_nettype wire

[rtl/adp_req_if.sv]
`default_nettype none

interface adp_req_if;
   import adp_pkg::*;

   logic     valid;
   logic     ready;
   byte_type text_byte;
   logic     last_byte;

   modport source (output valid, output text_byte, output last_byte, input ready);
   modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

`default_nettype wire

[rtl/adp_rsp_if.sv]
`default_nettype none

interface adp_rsp_if;
   import adp_pkg::*;

   logic       valid;
   logic       ready;
   value_type  parsed_value;
   count_type  consumed_count;
   logic [1:0] parse_status;

   modport source (output valid, output parsed_value, output consumed_count,
                   output parse_status, input ready);
   modport sink   (input valid, input parsed_value, input consumed_count,
                   input parse_status, output ready);
endinterface

`default_nettype wire

[rtl/adp_field_step.sv]
`default_nettype none

module adp_field_step (
   input  wire  adp_pkg::kind_type        kind,
   input  wire  adp_pkg::field_state_type cur,
   input  wire  adp_pkg::byte_type        text_byte,
   input  wire                            last_byte,
   output adp_pkg::field_state_type       nxt,
   output logic                           emit,
   output adp_pkg::result_type            result
);
   import adp_pkg::*;

   logic            is_signed;
   logic            is_digit;
   logic            is_null;
   logic            is_minus;
   byte_type        char_off;
   logic [3:0]      digit;
   logic            at_max;
   count_type       cnt_c;
   logic            ovf_c;
   logic [PROD_W-1:0] prod;
   logic [PROD_W-1:0] limit;
   field_state_type upd;
   field_state_type fin;
   logic            finish;
   logic            has_digits;
   value_type       pos_max;
   logic            mag_over;
   logic            neg_edge;
   logic            bad;

   always_comb begin
      is_signed = kind_is_signed(kind);
      is_digit  = text_byte inside {[CHAR_ZERO:CHAR_NINE]};
      is_null   = !cur.field_open && (text_byte == CHAR_NUL);
      is_minus  = !cur.field_open && (text_byte == CHAR_MINUS) && is_signed;
      char_off  = text_byte - CHAR_ZERO;
      digit     = char_off[3:0];

      // sign or digit byte counted, sticky error past the field limit
      at_max = cur.byte_count >= COUNT_W'(MAX_FIELD_BYTES);
      cnt_c  = at_max ? cur.byte_count : cur.byte_count + COUNT_W'(1);
      ovf_c  = cur.overflowed | at_max;

      // value*10 + digit, compared against the signed or unsigned magnitude limit
      prod  = {1'b0, cur.acc, 3'b000} + {3'b000, cur.acc, 1'b0} + PROD_W'(digit);
      limit = is_signed ? {4'b0000, 1'b1, {(VALUE_W-1){1'b0}}}
                        : {4'b0000, {VALUE_W{1'b1}}};

      upd            = cur;
      upd.field_open = 1'b1;
      upd.byte_count = cnt_c;
      upd.overflowed = ovf_c;
      if (is_minus) begin
         upd.minus_seen = 1'b1;
      end else if (!ovf_c) begin
         if (prod > limit) begin
            upd.overflowed = 1'b1;
         end else begin
            upd.acc = prod[VALUE_W-1:0];
         end
      end

      // a non-digit closes the field with the state as it stands
      fin    = (is_minus || is_digit) ? upd : cur;
      finish = !is_null && (!(is_minus || is_digit) || last_byte);

      has_digits = fin.byte_count > COUNT_W'(fin.minus_seen);
      pos_max    = kind_pos_max(kind);
      mag_over   = fin.acc > pos_max;
      neg_edge   = fin.acc == pos_max + VALUE_W'(1);
      bad = fin.overflowed || !has_digits || (fin.minus_seen && !is_signed)
            || (mag_over && !(fin.minus_seen && neg_edge));

      emit   = is_null || finish;
      result = '{parsed_value: '0, consumed_count: '0, parse_status: STATUS_ERROR};
      if (is_null) begin
         result.parse_status = STATUS_NULL;
      end else if (!bad) begin
         result.parsed_value   = fin.minus_seen ? value_type'(0) - fin.acc : fin.acc;
         result.consumed_count = fin.byte_count;
         result.parse_status   = STATUS_OK;
      end

      if (is_null) begin
         nxt = cur;
      end else if (finish) begin
         nxt = '0;
      end else begin
         nxt = upd;
      end
   end

endmodule

`default_nettype wire

[rtl/ascii_decimal_integer_parser_core.sv]
`default_nettype none

// Parses one decimal integer field from a stream of text bytes, one byte per
// transaction on req_ch. A field is an optional leading minus (signed kinds only)
// followed by digits; it closes at the first non-digit byte, which is swallowed
// as the delimiter, or at a byte flagged last_byte. A zero byte where a field
// would start yields a null result. Each field gives one transaction on rsp_ch
// with the value (sign-extended for signed kinds), the count of sign and digit
// bytes, and a status; errors return zero value and count. csr_wr_data selects
// the kind (int8..int64, uint8..uint64, reset int64); the user must write it
// only while the block is idle, and the block itself does not enforce this. It
// takes one byte every cycle unless rsp_ch back-pressure holds the result
// register; a closing byte goes through the input register, the combinational
// multiply-by-ten, add and range compare, and the result register to rsp_ch.
module ascii_decimal_integer_parser_core (
   input  wire                    clock,
   input  wire                    reset,
   adp_req_if.sink                req_ch,
   adp_rsp_if.source              rsp_ch,
   input  wire                    csr_wr_en,
   input  wire adp_pkg::kind_type csr_wr_data
);
   import adp_pkg::*;

   kind_type        kind_ff;
   logic            in_valid_ff;
   logic            in_valid_in;
   byte_type        in_byte_ff;
   logic            in_last_ff;
   field_state_type field_ff;
   field_state_type field_in;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   result_type      rsp_data_ff;
   logic            accept;
   logic            advance;
   logic            emit;
   result_type      result;

   adp_field_step u_step (
      .kind      (kind_ff),
      .cur       (field_ff),
      .text_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .nxt       (field_in),
      .emit      (emit),
      .result    (result)
   );

   // held byte moves on once the result register can take whatever it makes
   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = emit;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff      <= KIND_INT64;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         field_ff     <= '0;
      end else begin
         if (csr_wr_en) begin
            kind_ff <= csr_wr_data;
         end
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            field_ff <= field_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_ch.text_byte;
         in_last_ff <= req_ch.last_byte;
      end
      if (advance && emit) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.parsed_value   = rsp_data_ff.parsed_value;
   assign rsp_ch.consumed_count = rsp_data_ff.consumed_count;
   assign rsp_ch.parse_status   = rsp_data_ff.parse_status;

endmodule

`default_nettype wire

[bench/testbench.sv]
`default_nettype none

module testbench;
   import adp_pkg::*;

   // tracks the field being parsed and the results it must produce
   class field_tracker;
      kind_type   kind;
      value_type  acc;
      logic       minus;
      count_type  nbytes;
      logic       failed;
      logic       open_field;
      result_type expected_fields[$];
      int         mismatches;

      function new();
         kind = KIND_INT64;
         mismatches = 0;
         clear();
      endfunction

      function void clear();
         acc = '0;
         minus = 1'b0;
         nbytes = '0;
         failed = 1'b0;
         open_field = 1'b0;
      endfunction

      function void bump_count();
         if (nbytes >= COUNT_W'(MAX_FIELD_BYTES))
            failed = 1'b1;
         else
            nbytes++;
      endfunction

      function void add_digit(logic [3:0] d);
         value_type lim;
         lim = (kind < KIND_UINT8) ? 64'h8000_0000_0000_0000 : '1;
         bump_count();
         if (failed)
            return;
         if (acc > (lim - value_type'(d)) / 64'd10)
            failed = 1'b1;
         else
            acc = acc * 64'd10 + value_type'(d);
      endfunction

      function void close_field();
         result_type r;
         logic       sgn;
         logic       bad;
         int         w;
         value_type  half;
         value_type  umax;
         value_type  v;
         sgn = kind < KIND_UINT8;
         w = 8 << kind[1:0];
         bad = failed || !(nbytes > count_type'(minus)) || (minus && !sgn);
         v = '0;
         if (!bad) begin
            if (sgn) begin
               half = 64'd1 << (w - 1);
               if (minus) begin
                  if (acc > half) bad = 1'b1;
                  else v = -acc;
               end else begin
                  if (acc > half - 64'd1) bad = 1'b1;
                  else v = acc;
               end
            end else begin
               umax = (w == 64) ? '1 : (64'd1 << w) - 64'd1;
               if (acc > umax) bad = 1'b1;
               else v = acc;
            end
         end
         r.parsed_value = bad ? '0 : v;
         r.consumed_count = bad ? '0 : nbytes;
         r.parse_status = bad ? STATUS_ERROR : STATUS_OK;
         expected_fields.push_back(r);
         clear();
      endfunction

      // called for every accepted request transaction
      function void note_byte(byte_type b, logic is_last);
         result_type r;
         logic       is_dig;
         is_dig = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
         if (!open_field && b == CHAR_NUL) begin
            r.parsed_value = '0;
            r.consumed_count = '0;
            r.parse_status = STATUS_NULL;
            expected_fields.push_back(r);
         end else if (!open_field && b == CHAR_MINUS && kind < KIND_UINT8) begin
            open_field = 1'b1;
            minus = 1'b1;
            bump_count();
            if (is_last) close_field();
         end else if (!is_dig) begin
            close_field();
         end else begin
            open_field = 1'b1;
            add_digit(4'(b - CHAR_ZERO));
            if (is_last) close_field();
         end
      endfunction

      function void compare_field(value_type v, count_type c, logic [1:0] s);
         result_type e;
         if (expected_fields.size() == 0) begin
            $display("%0t: unexpected result value=%h count=%0d status=%0d", $time, v, c, s);
            mismatches++;
            return;
         end
         e = expected_fields.pop_front();
         if (e.parsed_value !== v) begin
            $display("%0t: parsed_value expected %h actual %h", $time, e.parsed_value, v);
            mismatches++;
         end
         if (e.consumed_count !== c) begin
            $display("%0t: consumed_count expected %0d actual %0d", $time, e.consumed_count, c);
            mismatches++;
         end
         if (e.parse_status !== s) begin
            $display("%0t: parse_status expected %0d actual %0d", $time, e.parse_status, s);
            mismatches++;
         end
      endfunction
   endclass

   logic     clock;
   logic     reset;
   logic     csr_wr_en;
   kind_type csr_wr_data;

   adp_req_if req_bus ();
   adp_rsp_if rsp_bus ();

   field_tracker tracker = new();

   int send_idle_pct;
   int recv_idle_pct;
   int bytes_sent;

   ascii_decimal_integer_parser_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_bus),
      .rsp_ch      (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #10 clock = ~clock;

   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
         tracker.compare_field(rsp_bus.parsed_value, rsp_bus.consumed_count,
                               rsp_bus.parse_status);
   end

   task automatic send_byte(input byte_type b, input logic is_last);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         req_bus.text_byte <= byte_type'($urandom);
         req_bus.last_byte <= 1'($urandom);
      end
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.text_byte <= b;
      req_bus.last_byte <= is_last;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      tracker.note_byte(b, is_last);
      bytes_sent++;
   endtask

   task automatic send_text(input string s, input logic last_on_end);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i], last_on_end && (i == s.len() - 1));
   endtask

   // let every pending result come back before touching the register
   task automatic drain();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (tracker.expected_fields.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_kind(input kind_type k);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= k;
      @(posedge clock);
      tracker.kind = k;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_field();
      int        pick;
      int        sel;
      int        w;
      int        n;
      string     digits;
      value_type mag;
      kind_type  bk;
      logic      neg;
      byte_type  delim;
      pick = $urandom_range(99);
      digits = "";
      if (pick < 60) begin
         // well-formed number, mostly near some kind's range limits
         bk = $urandom_range(1) ? tracker.kind : kind_type'($urandom_range(7));
         w = 8 << bk[1:0];
         sel = $urandom_range(7);
         case (sel)
            0: mag = (64'd1 << (w - 1)) - 64'd1;
            1: mag = 64'd1 << (w - 1);
            2: mag = (64'd1 << (w - 1)) + 64'd1;
            3: mag = (w == 64) ? '1 : (64'd1 << w) - 64'd1;
            4: mag = (w == 64) ? '1 : (64'd1 << w);
            5: mag = 64'($urandom_range(20));
            default: mag = {$urandom, $urandom} >> $urandom_range(63);
         endcase
         digits = $sformatf("%0d", mag);
         if (sel == 4 && w == 64) digits = "18446744073709551616";
         if ($urandom_range(7) == 0) digits = {"00", digits};
      end else if (pick < 68) begin
         repeat ($urandom_range(20, 24))
            digits = {digits, $sformatf("%0d", $urandom_range(9))};
      end else if (pick < 71) begin
         // zeros around the field length limit
         n = $urandom_range(62, 67);
         repeat (n) digits = {digits, "0"};
         digits = {digits, "7"};
      end else if (pick < 85) begin
         send_byte(byte_type'($urandom), 1'($urandom_range(1)));
         return;
      end else begin
         repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(3))
               0: delim = CHAR_MINUS;
               1, 2: delim = CHAR_ZERO + byte_type'($urandom_range(9));
               default: delim = byte_type'($urandom);
            endcase
            send_byte(delim, $urandom_range(3) == 0);
         end
         return;
      end
      neg = (tracker.kind < KIND_UINT8) ? 1'($urandom_range(1)) : ($urandom_range(9) == 0);
      if (neg) digits = {"-", digits};
      if ($urandom_range(1)) begin
         send_text(digits, 1'b1);
      end else begin
         send_text(digits, 1'b0);
         do delim = byte_type'($urandom); while (delim >= CHAR_ZERO && delim <= CHAR_NINE);
         send_byte(delim, 1'($urandom_range(1)));
      end
   endtask

   initial begin
      kind_type phase_kinds[8];
      int       start;
      phase_kinds = '{KIND_UINT64, KIND_INT8, KIND_INT64, KIND_UINT8,
                      KIND_INT16, KIND_UINT32, KIND_INT32, KIND_UINT16};
      clock = 1'b0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.text_byte = '0;
      req_bus.last_byte = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = KIND_INT64;
      send_idle_pct = 8;
      recv_idle_pct = 75;
      bytes_sent = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed cases under the reset kind, then int8 and uint8
      send_byte(CHAR_NUL, 1'b0);
      send_byte(8'hFF, 1'b1);
      drain();
      write_kind(KIND_INT8);
      send_text("-", 1'b1);
      send_text("-,", 1'b0);
      send_text("127", 1'b1);
      send_text("-128 ", 1'b0);
      send_text("128;", 1'b0);
      send_text("-0", 1'b1);
      // field left open across a kind change
      send_text("-1", 1'b0);
      drain();
      write_kind(KIND_UINT8);
      send_text("2", 1'b1);
      send_text("-", 1'b0);
      send_text("255", 1'b1);

      for (int phase = 0; phase < 9; phase++) begin
         drain();
         write_kind(phase < 8 ? phase_kinds[phase] : kind_type'($urandom_range(7)));
         if (phase < 3) begin
            send_idle_pct = 8;
            recv_idle_pct = 75;
         end else if (phase < 6) begin
            send_idle_pct = 75;
            recv_idle_pct = 8;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         start = bytes_sent;
         while (bytes_sent - start < 60) random_field();
      end
      drain();

      if (tracker.mismatches == 0)
         $display("PASS ascii_decimal_integer_parser_core");
      else
         $display("FAIL ascii_decimal_integer_parser_core");
      $finish;
   end

   initial begin
      #4000000;
      $display("FAIL ascii_decimal_integer_parser_core");
      $finish;
   end

endmodule

`default_nettype wire
